// ===== rtl/prz_pkg.sv =====
package prz_pkg;

    // source rows are limited independently of the store size
    localparam int ROW_LIMIT  = 1024;
    localparam int ROW_W      = 10;
    localparam int ROWS_W     = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_FETCH = 1'b1
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_COLS = 2'd0,
        REG_IMAGE_ROWS = 2'd1,
        REG_MAG_FACTOR = 2'd2,
        REG_FLIP_ROWS  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_padding;
        logic       row_last;
        logic       image_last;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic       is_fetch;
        logic [7:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ===== rtl/prz_front.sv =====
module prz_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  prz_pkg::in_item_t  s_data,
    output logic               f_valid,
    input  logic               f_ready,
    output prz_pkg::cmd_t      f_cmd
);

    logic          hold_valid_reg;
    prz_pkg::cmd_t cmd_reg;
    prz_pkg::cmd_t cmd_next;

    assign s_ready = !hold_valid_reg || f_ready;
    assign f_valid = hold_valid_reg;
    assign f_cmd   = cmd_reg;

    always_comb begin
        cmd_next.is_fetch = (s_data.req_type == prz_pkg::REQ_FETCH);
        cmd_next.pixel    = s_data.pixel_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (f_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== rtl/prz_queue.sv =====
module prz_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  prz_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output prz_pkg::cmd_t rd_cmd
);

    prz_pkg::cmd_t                entry_reg [prz_pkg::QDEPTH];
    logic [prz_pkg::QPTR_W-1:0]   wptr_reg;
    logic [prz_pkg::QPTR_W-1:0]   rptr_reg;
    logic [prz_pkg::QCNT_W-1:0]   count_reg;
    logic                         push;
    logic                         pop;

    assign wr_ready = (count_reg != prz_pkg::QCNT_W'(prz_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/prz_back.sv =====
module prz_back #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_COLS   = 1024,
    parameter int MAX_MAG    = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  prz_pkg::cfg_wr_t   cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  prz_pkg::cmd_t      q_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output prz_pkg::out_item_t m_data
);

    localparam int AW     = $clog2(MAX_PIXELS);
    localparam int LCW    = $clog2(MAX_PIXELS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int MAG_W  = $clog2(MAX_MAG + 1);
    localparam int ROW_W  = prz_pkg::ROW_W;
    localparam int ROWS_W = prz_pkg::ROWS_W;
    localparam int PROD_W = ROW_W + COL_W;
    localparam int SUM_W  = (PROD_W + 1 > AW + 1) ? PROD_W + 1 : AW + 1;
    localparam int CMP_W  = (COL_W > prz_pkg::CFG_DATA_W) ? COL_W : prz_pkg::CFG_DATA_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_OUT
    } state_t;

    state_t                       state_reg;
    logic [prz_pkg::CFG_DATA_W-1:0] image_cols_reg;
    logic [ROWS_W-1:0]            image_rows_reg;
    logic [3:0]                   mag_factor_reg;
    logic                         flip_rows_reg;
    logic                         restart_reg;
    logic [LCW-1:0]               load_count_reg;
    logic                         overflow_reg;
    logic [ROW_W-1:0]             src_row_reg;
    logic [MAG_W-1:0]             line_rep_reg;
    logic [COL_W-1:0]             src_col_reg;
    logic [MAG_W-1:0]             pix_rep_reg;
    logic [1:0]                   pad_cnt_reg;

    logic [PROD_W-1:0]            prod_reg;
    logic [COL_W-1:0]             col_q_reg;
    logic                         pad_q_reg;
    logic                         rlast_q_reg;
    logic                         ilast_q_reg;
    logic                         ovf_q_reg;
    logic [7:0]                   rd_data_reg;
    logic                         in_range_reg;
    logic                         m_valid_reg;
    prz_pkg::out_item_t           m_data_reg;

    logic [7:0]                   mem [MAX_PIXELS];

    logic [COL_W-1:0]             cols_eff;
    logic [ROWS_W-1:0]            rows_eff;
    logic [MAG_W-1:0]             mag_eff;
    logic [1:0]                   data_low;
    logic [1:0]                   pad_total;
    logic [ROW_W-1:0]             first_row;

    logic [MAG_W:0]               pix_inc;
    logic [MAG_W:0]               line_inc;
    logic [COL_W-1:0]             col_inc;
    logic [2:0]                   pad_inc;
    logic [ROWS_W-1:0]            row_inc;
    logic                         at_last;

    logic [COL_W-1:0]             col_step;
    logic [MAG_W-1:0]             pix_step;
    logic [1:0]                   pad_step;
    logic [MAG_W-1:0]             line_step;
    logic [ROW_W-1:0]             row_step;
    logic                         pad_step_flag;
    logic                         rlast_step;
    logic                         ilast_step;

    logic                         pop;
    logic                         load_ok;
    logic                         out_free;
    logic [PROD_W-1:0]            prod_val;
    logic [SUM_W-1:0]             addr_sum;

    // clamp the registers to their legal ranges
    always_comb begin
        priority if (image_cols_reg == '0) begin
            cols_eff = COL_W'(1);
        end else if (CMP_W'(image_cols_reg) > CMP_W'(MAX_COLS)) begin
            cols_eff = COL_W'(MAX_COLS);
        end else begin
            cols_eff = COL_W'(image_cols_reg);
        end
        priority if (image_rows_reg == '0) begin
            rows_eff = ROWS_W'(1);
        end else if (image_rows_reg > ROWS_W'(prz_pkg::ROW_LIMIT)) begin
            rows_eff = ROWS_W'(prz_pkg::ROW_LIMIT);
        end else begin
            rows_eff = image_rows_reg;
        end
        priority if (mag_factor_reg == '0) begin
            mag_eff = MAG_W'(1);
        end else if (5'(mag_factor_reg) > 5'(MAX_MAG)) begin
            mag_eff = MAG_W'(MAX_MAG);
        end else begin
            mag_eff = MAG_W'(mag_factor_reg);
        end
    end

    // row padding only depends on the row length mod 4
    assign data_low  = 2'(2'(mag_eff) * 2'(cols_eff));
    assign pad_total = 2'(2'd0 - data_low);
    assign first_row = flip_rows_reg ? ROW_W'(rows_eff - 1'b1) : '0;

    assign pix_inc  = {1'b0, pix_rep_reg} + 1'b1;
    assign line_inc = {1'b0, line_rep_reg} + 1'b1;
    assign col_inc  = src_col_reg + 1'b1;
    assign pad_inc  = {1'b0, pad_cnt_reg} + 3'd1;
    assign row_inc  = {1'b0, src_row_reg} + 1'b1;
    assign at_last  = flip_rows_reg ? (src_row_reg == '0) : (row_inc >= rows_eff);

    // raster position advance for one fetch
    always_comb begin
        col_step      = src_col_reg;
        pix_step      = pix_rep_reg;
        pad_step      = pad_cnt_reg;
        line_step     = line_rep_reg;
        row_step      = src_row_reg;
        pad_step_flag = 1'b0;
        rlast_step    = 1'b0;
        ilast_step    = 1'b0;
        if (src_col_reg < cols_eff) begin
            if (pix_inc >= {1'b0, mag_eff}) begin
                pix_step = '0;
                col_step = col_inc;
            end else begin
                pix_step = pix_inc[MAG_W-1:0];
            end
            rlast_step = (col_step >= cols_eff) && (pad_total == 2'd0);
        end else begin
            pad_step_flag = 1'b1;
            pad_step      = pad_inc[1:0];
            rlast_step    = (pad_inc >= {1'b0, pad_total});
        end
        if (rlast_step) begin
            col_step = '0;
            pix_step = '0;
            pad_step = '0;
            if (line_inc >= {1'b0, mag_eff}) begin
                line_step = '0;
                priority if (at_last) begin
                    ilast_step = 1'b1;
                    row_step   = first_row;
                end else if (flip_rows_reg) begin
                    row_step = src_row_reg - 1'b1;
                end else begin
                    row_step = row_inc[ROW_W-1:0];
                end
            end else begin
                line_step = line_inc[MAG_W-1:0];
            end
        end
    end

    assign q_ready  = (state_reg == ST_IDLE) && !restart_reg;
    assign pop      = q_valid && q_ready;
    assign load_ok  = (load_count_reg < LCW'(MAX_PIXELS));
    assign out_free = !m_valid_reg || m_ready;
    assign prod_val = PROD_W'(src_row_reg) * PROD_W'(cols_eff);
    assign addr_sum = SUM_W'(prod_reg) + SUM_W'(col_q_reg);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            image_cols_reg <= prz_pkg::CFG_DATA_W'(1);
            image_rows_reg <= ROWS_W'(1);
            mag_factor_reg <= 4'd1;
            flip_rows_reg  <= 1'b1;
            restart_reg    <= 1'b0;
            load_count_reg <= '0;
            overflow_reg   <= 1'b0;
            src_row_reg    <= '0;
            line_rep_reg   <= '0;
            src_col_reg    <= '0;
            pix_rep_reg    <= '0;
            pad_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // in ST_OUT a new result takes the place of the one leaving
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            // any write sets restart_reg; the raster then restarts with the new values once writes stop
            if (cfg.en) begin
                unique case (prz_pkg::reg_index_t'(cfg.index))
                    prz_pkg::REG_IMAGE_COLS: image_cols_reg <= cfg.data;
                    prz_pkg::REG_IMAGE_ROWS: image_rows_reg <= cfg.data;
                    prz_pkg::REG_MAG_FACTOR: mag_factor_reg <= cfg.data[3:0];
                    prz_pkg::REG_FLIP_ROWS:  flip_rows_reg  <= cfg.data[0];
                endcase
                restart_reg <= 1'b1;
            end else if (restart_reg) begin
                src_row_reg  <= first_row;
                line_rep_reg <= '0;
                src_col_reg  <= '0;
                pix_rep_reg  <= '0;
                pad_cnt_reg  <= '0;
                restart_reg  <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        if (q_cmd.is_fetch) begin
                            src_row_reg  <= row_step;
                            line_rep_reg <= line_step;
                            src_col_reg  <= col_step;
                            pix_rep_reg  <= pix_step;
                            pad_cnt_reg  <= pad_step;
                            state_reg    <= ST_ADDR;
                        end else if (load_ok) begin
                            load_count_reg <= load_count_reg + 1'b1;
                        end else begin
                            overflow_reg <= 1'b1;
                        end
                    end
                end
                ST_ADDR: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_cmd.is_fetch) begin
            prod_reg    <= prod_val;
            col_q_reg   <= src_col_reg;
            pad_q_reg   <= pad_step_flag;
            rlast_q_reg <= rlast_step;
            ilast_q_reg <= ilast_step;
            ovf_q_reg   <= overflow_reg;
        end
        if (state_reg == ST_ADDR) begin
            in_range_reg <= (addr_sum < SUM_W'(MAX_PIXELS));
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_data_reg.out_byte   <= (pad_q_reg || !in_range_reg) ? 8'd0 : rd_data_reg;
            m_data_reg.is_padding <= pad_q_reg;
            m_data_reg.row_last   <= rlast_q_reg;
            m_data_reg.image_last <= ilast_q_reg;
            m_data_reg.overflow   <= ovf_q_reg;
        end
    end

    // frame store: one write port for loads, one registered read for fetches
    always_ff @(posedge aclk) begin
        if (pop && !q_cmd.is_fetch && load_ok) begin
            mem[load_count_reg[AW-1:0]] <= q_cmd.pixel;
        end
        if (state_reg == ST_ADDR) begin
            rd_data_reg <= mem[addr_sum[AW-1:0]];
        end
    end

endmodule

// ===== rtl/pixel_replicate_zoom_raster_core.sv =====
// Pixel-replication zoom: load items (req_type 0) fill the frame store in raster
// order, one pixel per transfer, and fetch items (req_type 1) each return one byte
// of the zoomed, 4-byte-aligned output raster with row_last/image_last marks. A
// front stage and a two-entry queue hold up to three items while the execution
// unit works, so the input keeps accepting for a while when a result waits on
// m_ready. In the execution unit a load is stored from the idle state, and a fetch goes
// through position update and address multiply, frame store read and output register,
// where it waits while an earlier result is held. Each item finishes before the next is
// taken. A register write restarts the raster at its first byte; loaded pixels and the
// load count are kept. Loads past MAX_PIXELS are dropped and set the sticky
// overflow bit.
module pixel_replicate_zoom_raster_core #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_COLS   = 1024,
    parameter int MAX_MAG    = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [prz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prz_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  prz_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output prz_pkg::out_item_t                m_data
);

    prz_pkg::cfg_wr_t cfg;
    logic             f_valid;
    logic             f_ready;
    prz_pkg::cmd_t    f_cmd;
    logic             q_valid;
    logic             q_ready;
    prz_pkg::cmd_t    q_cmd;

    always_comb begin
        cfg.en    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_wdata;
    end

    prz_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_cmd   (f_cmd)
    );

    prz_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    prz_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_COLS   (MAX_COLS),
        .MAX_MAG    (MAX_MAG)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/prz_checker.sv =====
module prz_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input prz_pkg::out_item_t m_data
);

    logic seen_ovf_reg;

    // overflow is sticky until reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_ovf_reg <= 1'b0;
        end else if (m_valid && m_ready && m_data.overflow) begin
            seen_ovf_reg <= 1'b1;
        end
    end

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_padding |-> (m_data.out_byte == 8'd0))
        else $error("padding byte is not zero");

    a_image_row_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.image_last |-> m_data.row_last)
        else $error("image end without row end");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_ovf_reg |-> m_data.overflow)
        else $error("overflow flag dropped");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind pixel_replicate_zoom_raster_core prz_checker u_prz_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/pixel_replicate_zoom_raster_core_tb.sv =====
module pixel_replicate_zoom_raster_core_tb;

    localparam int MAX_PIXELS = 65536;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_MAG    = 8;
    localparam int SETTLE     = 16;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [prz_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [prz_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    prz_pkg::in_item_t              s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    prz_pkg::out_item_t             m_data;

    pixel_replicate_zoom_raster_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    // zoom predictor state
    logic [7:0]      fstore [0:MAX_PIXELS-1];
    int unsigned     n_loaded = 0;
    bit              ovf_seen = 1'b0;
    logic [10:0]     cfg_cols = 11'd1;
    logic [10:0]     cfg_rows = 11'd1;
    logic [3:0]      cfg_mag  = 4'd1;
    logic            cfg_flip = 1'b1;
    int unsigned     row_pos, line_rep, col_pos, pix_rep, pad_cnt;

    // look-ahead of store addresses a run of fetches will read
    bit              probe_only = 1'b0;
    int unsigned     probe_top = 0;

    prz_pkg::out_item_t raster_q [$];
    int              err_cnt = 0;
    int              items_sent = 0;
    bit              quiet = 1'b0;
    int              stall_left = 0;

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_cols();
        return clamp_cfg(cfg_cols, MAX_COLS);
    endfunction

    function automatic int unsigned eff_rows();
        return clamp_cfg(cfg_rows, prz_pkg::ROW_LIMIT);
    endfunction

    function automatic int unsigned eff_mag();
        return clamp_cfg(cfg_mag, MAX_MAG);
    endfunction

    function automatic int unsigned top_row();
        return cfg_flip ? eff_rows() - 1 : 0;
    endfunction

    function automatic void rewind_raster();
        row_pos  = top_row();
        line_rep = 0;
        col_pos  = 0;
        pix_rep  = 0;
        pad_cnt  = 0;
    endfunction

    function automatic void cfg_model(prz_pkg::reg_index_t idx,
                                      logic [prz_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            prz_pkg::REG_IMAGE_COLS: cfg_cols = val;
            prz_pkg::REG_IMAGE_ROWS: cfg_rows = val;
            prz_pkg::REG_MAG_FACTOR: cfg_mag  = val[3:0];
            prz_pkg::REG_FLIP_ROWS:  cfg_flip = val[0];
            default: ;
        endcase
        rewind_raster();
    endfunction

    function automatic void zoom_step(prz_pkg::in_item_t it);
        int unsigned ncols, nrows, nmag, row_bytes, pad_total, addr;
        bit          at_end;
        prz_pkg::out_item_t res;
        ncols     = eff_cols();
        nrows     = eff_rows();
        nmag      = eff_mag();
        row_bytes = nmag * ncols;
        pad_total = ((row_bytes + 3) / 4) * 4 - row_bytes;
        res       = '0;
        if (it.req_type == prz_pkg::REQ_LOAD) begin
            if (n_loaded >= MAX_PIXELS) begin
                ovf_seen = 1'b1;
            end else begin
                fstore[n_loaded] = it.pixel_value;
                n_loaded++;
            end
            return;
        end
        if (row_pos >= nrows) row_pos = top_row();
        if (col_pos < ncols) begin
            addr = row_pos * ncols + col_pos;
            if (addr < MAX_PIXELS && addr >= probe_top) probe_top = addr + 1;
            // pixels that fall past the store read back as zero data
            res.out_byte = (addr < MAX_PIXELS) ? fstore[addr] : 8'h00;
            pix_rep++;
            if (pix_rep >= nmag) begin
                pix_rep = 0;
                col_pos++;
            end
            if (col_pos >= ncols && pad_total == 0) res.row_last = 1'b1;
        end else begin
            res.is_padding = 1'b1;
            pad_cnt++;
            if (pad_cnt >= pad_total) res.row_last = 1'b1;
        end
        if (res.row_last) begin
            col_pos = 0;
            pix_rep = 0;
            pad_cnt = 0;
            line_rep++;
            if (line_rep >= nmag) begin
                at_end   = cfg_flip ? (row_pos == 0) : (row_pos + 1 >= nrows);
                line_rep = 0;
                if (at_end) begin
                    res.image_last = 1'b1;
                    row_pos = top_row();
                end else if (cfg_flip) begin
                    row_pos--;
                end else begin
                    row_pos++;
                end
            end
        end
        res.overflow = ovf_seen;
        if (!probe_only) raster_q.push_back(res);
    endfunction

    // loads needed so that the next n fetches only read written pixels
    function automatic int unsigned loads_needed(int n);
        int unsigned       sv_row, sv_line, sv_col, sv_pix, sv_pad;
        prz_pkg::in_item_t probe;
        sv_row  = row_pos;
        sv_line = line_rep;
        sv_col  = col_pos;
        sv_pix  = pix_rep;
        sv_pad  = pad_cnt;
        probe          = '0;
        probe.req_type = prz_pkg::REQ_FETCH;
        probe_top      = 0;
        probe_only     = 1'b1;
        repeat (n) zoom_step(probe);
        probe_only = 1'b0;
        row_pos    = sv_row;
        line_rep   = sv_line;
        col_pos    = sv_col;
        pix_rep    = sv_pix;
        pad_cnt    = sv_pad;
        return probe_top;
    endfunction

    function automatic void check_field(string fld, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 50)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin : chk_raster
        prz_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (raster_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 50)
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, m_data);
            end else begin
                want = raster_q.pop_front();
                check_field("out_byte", want.out_byte, m_data.out_byte);
                check_field("is_padding", 8'(want.is_padding), 8'(m_data.is_padding));
                check_field("row_last", 8'(want.row_last), 8'(m_data.row_last));
                check_field("image_last", 8'(want.image_last), 8'(m_data.image_last));
                check_field("overflow", 8'(want.overflow), 8'(m_data.overflow));
            end
        end
    end

    // receiver stalls, mostly short with some long ones
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 15)
                stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [10:0] pick_dim(bit big_ok, int unsigned typical);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 11'd0;
        if (big_ok && r < 18) return 11'd2047;
        if (big_ok && r < 26) return 11'd1024;
        if (big_ok && r < 34) return 11'($urandom_range(10, 2047));
        return 11'($urandom_range(1, typical));
    endfunction

    task automatic send_item(prz_pkg::req_kind_t kind, logic [7:0] px, int gap);
        prz_pkg::in_item_t it;
        it.req_type    = kind;
        it.pixel_value = px;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        zoom_step(it);
        items_sent++;
    endtask

    // hold the sender until every expected byte is back and the core is quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (raster_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(prz_pkg::reg_index_t idx,
                             logic [prz_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_model(idx, val);
    endtask

    task automatic set_config(logic [10:0] cols_w, logic [10:0] rows_w,
                              logic [10:0] mag_w, logic [10:0] flip_w);
        write_reg(prz_pkg::REG_IMAGE_COLS, cols_w);
        write_reg(prz_pkg::REG_IMAGE_ROWS, rows_w);
        write_reg(prz_pkg::REG_MAG_FACTOR, mag_w);
        write_reg(prz_pkg::REG_FLIP_ROWS, flip_w);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        // 1x1 image, mag 1, flipped: one data byte then three pad bytes, then wrap
        send_item(prz_pkg::REQ_LOAD, 8'hA5, pick_gap());
        repeat (5) send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
    endtask

    task automatic test_small_frame();
        wait_idle();
        set_config(11'd2, 11'd2, 11'd1, 11'd0);
        send_item(prz_pkg::REQ_LOAD, 8'h00, pick_gap());
        send_item(prz_pkg::REQ_LOAD, 8'hFF, pick_gap());
        send_item(prz_pkg::REQ_LOAD, 8'h5A, pick_gap());
        repeat (6) send_item(prz_pkg::REQ_FETCH, 8'hFF, pick_gap());
    endtask

    task automatic test_restart_on_write();
        // single write mid-image, raster must start over bottom row first
        wait_idle();
        write_reg(prz_pkg::REG_FLIP_ROWS, 11'd1);
        cfg_we <= 1'b0;
        repeat (4) send_item(prz_pkg::REQ_FETCH, 8'h00, pick_gap());
    endtask

    task automatic test_no_padding();
        wait_idle();
        set_config(11'd1, 11'd1, 11'd4, 11'd1);
        repeat (5) send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
    endtask

    task automatic test_past_store();
        // bottom row sits past the store, so data bytes come back as zero
        wait_idle();
        set_config(11'd1024, 11'd1024, 11'd1, 11'd1);
        repeat (6) send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
    endtask

    task automatic test_register_clamps();
        while (n_loaded < 8)
            send_item(prz_pkg::REQ_LOAD, 8'($urandom), pick_gap());
        wait_idle();
        set_config(11'd0, 11'd2047, 11'h7F0, 11'h7FE);
        repeat (6) send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
        wait_idle();
        set_config(11'd2047, 11'd0, 11'h00F, 11'h001);
        repeat (10) send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
        wait_idle();
        set_config(11'd3, 11'd2, 11'h7A2, 11'h555);
        repeat (12) send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
    endtask

    task automatic test_random_raster(int budget, bit big_ok);
        int          start, n_fetch, r;
        int unsigned total, need;
        logic [10:0] cols_w, rows_w, mag_w, flip_w;
        logic [3:0]  mag_v;
        start = items_sent;
        while (items_sent - start < budget) begin
            quiet  = ($urandom_range(0, 4) == 0);
            cols_w = pick_dim(big_ok, 9);
            rows_w = pick_dim(big_ok, 5);
            r      = $urandom_range(0, 99);
            if (r < 10)      mag_v = 4'd0;
            else if (r < 22) mag_v = 4'd8;
            else if (r < 30) mag_v = 4'($urandom_range(9, 15));
            else             mag_v = 4'($urandom_range(1, 8));
            // upper bits of the narrow registers carry junk
            mag_w  = {7'($urandom), mag_v};
            flip_w = 11'($urandom);
            wait_idle();
            set_config(cols_w, rows_w, mag_w, flip_w);
            total   = eff_rows() * eff_mag() * (((eff_cols() * eff_mag() + 3) / 4) * 4);
            n_fetch = (total <= 150 && $urandom_range(0, 1) == 1)
                      ? total + $urandom_range(0, 6) : $urandom_range(1, 40);
            need    = loads_needed(n_fetch);
            // shapes that start deep inside an unloaded store are skipped
            if (need <= n_loaded + 48) begin
                while (n_loaded < need)
                    send_item(prz_pkg::REQ_LOAD, 8'($urandom), pick_gap());
                repeat (n_fetch) begin
                    r = $urandom_range(0, 99);
                    if (r < 12) begin
                        send_item(prz_pkg::REQ_LOAD, 8'($urandom), pick_gap());
                    end else begin
                        if (r < 14) wait_idle();
                        send_item(prz_pkg::REQ_FETCH, 8'($urandom), pick_gap());
                    end
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        rewind_raster();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_small_frame();
        test_restart_on_write();
        test_no_padding();
        test_random_raster(150, 1'b0);
        test_past_store();
        test_register_clamps();
        test_random_raster(150, 1'b1);
        wait_idle();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("%0t: timeout, %0d transfers still expected", $time, raster_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
